>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the coverage grid.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

>>> hw/rtl/dcg_pkg.sv
// Shared types and constants of the decaying coverage grid.
// No dependencies; imported by decaying_coverage_grid_unit.
package dcg_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int IDX_W    = $clog2(CELLS);
  localparam int CNT_W    = $clog2(CELLS + 1);
  // The covered counter can run past the result width after threshold changes.
  localparam int COV_W    = 32;
  localparam int LVL_W    = 17;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = 2 * LVL_W;
  localparam int WORD_W   = LVL_W + 1;
  localparam logic [LVL_W-1:0] ONE_Q16 = LVL_W'(1 << FRAC_W);
  localparam logic [8:0] COUNT_SAT = 9'h1FF;

  typedef enum logic [2:0] {
    OP_CLEAR_ALL    = 3'd0,
    OP_LOAD         = 3'd1,
    OP_CLEAR_LEVELS = 3'd2,
    OP_MARK         = 3'd3,
    OP_FADE         = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    REG_GRID_ROWS   = 2'd0,
    REG_GRID_COLS   = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_FADE_FACTOR = 2'd3
  } reg_index_t;

endpackage

>>> hw/rtl/dcg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module dcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/decaying_coverage_grid_unit.sv
// Decaying coverage grid: cell levels and passable mask in one RAM, plus counters.
// Depends on dcg_pkg, dcg_ram and assert_macros.svh.
//
// Usage: items enter on in_valid/in_stall carrying opcode, row, col,
// cell_is_wall and mark_amount. Every item produces exactly one result item on
// out_valid/out_stall with covered_count and passable_cells (floored at 1).
// The block handles one item at a time and stalls the input while busy.
// Cell load and mark read the cell's RAM word on accept, read-modify-write the
// cell, then post the result.
// Clear-all, unused opcodes and cells outside the grid go straight to posting
// the result; clear-all drops the per-cell valid bits at once.
// Fade and clear-levels walk every cell of the store through a three-stage
// read, multiply, write pipeline around the single level multiplier.
// Results sit in an output register; a stalled result holds the block in its
// final step only when a new result is ready and the register is still full.
// Reset clears all cells (through per-cell valid bits), both counters and the
// output valid flag, and loads the configuration defaults; no clearing pass.
// Configuration is an APB-style port, one 32-bit register every 4 bytes.
`include "assert_macros.svh"
module decaying_coverage_grid_unit import dcg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            opcode,
  input  logic [3:0]            row,
  input  logic [3:0]            col,
  input  logic                  cell_is_wall,
  input  logic [16:0]           mark_amount,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [8:0]            covered_count,
  output logic [8:0]            passable_cells
);

  // Configuration registers.
  logic [4:0]       grid_rows;
  logic [4:0]       grid_cols;
  logic [LVL_W-1:0] cover_threshold;
  logic [LVL_W-1:0] fade_factor;

  // Control state.
  state_t           state, state_next;
  opcode_t          op_q;
  logic [IDX_W-1:0] idx_q;
  logic             wall_q;
  logic [LVL_W-1:0] amount_q;
  logic [CNT_W-1:0] rd_idx;
  logic             s1_vld, s2_vld;
  logic [IDX_W-1:0] s1_idx, s2_idx;
  logic             s2_pass;
  logic [PROD_W-1:0] prod_q;
  logic [COV_W-1:0] covered_counter;
  logic [CNT_W-1:0] passable_counter;
  logic [CELLS-1:0] cell_valid;
  logic             rvalid_q;

  // RAM port signals.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic              cfg_wr;
  reg_index_t        cfg_idx;
  logic              in_accept;
  logic              out_free;
  logic              post_result;
  opcode_t           op_in;
  logic              cell_hit;
  logic [IDX_W-1:0]  in_idx;
  logic [WORD_W-1:0] rd_word;
  logic              rd_pass;
  logic [LVL_W-1:0]  rd_lvl;
  logic [LVL_W:0]    mark_sum;
  logic [LVL_W-1:0]  mark_lvl;
  logic [PROD_W-FRAC_W-1:0] prod_hi;
  logic [LVL_W-1:0]  sweep_lvl;
  logic              issue;
  logic              sweep_done;

  dcg_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_level_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_index_t'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_GRID_ROWS:   prdata = 32'(grid_rows);
      REG_GRID_COLS:   prdata = 32'(grid_cols);
      REG_THRESHOLD:   prdata = 32'(cover_threshold);
      REG_FADE_FACTOR: prdata = 32'(fade_factor);
      default:         prdata = '0;
    endcase
  end

  // Input decode.
  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign post_result = (state == ST_FINISH) && out_free;
  assign op_in       = opcode_t'(opcode);
  assign cell_hit  = (int'(row) < int'(grid_rows)) && (int'(row) < MAX_ROWS) &&
                     (int'(col) < int'(grid_cols)) && (int'(col) < MAX_COLS);
  assign in_idx    = IDX_W'(int'(row) * MAX_COLS + int'(col));

  // A cell that was never written since the last clear reads as zero.
  assign rd_word = rvalid_q ? ram_rdata : '0;
  assign rd_pass = rd_word[LVL_W];
  assign rd_lvl  = rd_word[LVL_W-1:0];

  assign mark_sum = {1'b0, rd_lvl} + {1'b0, amount_q};
  assign mark_lvl = (mark_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : mark_sum[LVL_W-1:0];

  assign prod_hi   = prod_q[PROD_W-1:FRAC_W];
  assign sweep_lvl = (op_q != OP_FADE) ? '0 :
                     (prod_hi > (PROD_W-FRAC_W)'(ONE_Q16)) ? ONE_Q16 :
                     prod_hi[LVL_W-1:0];

  assign issue      = (state == ST_SWEEP) && (rd_idx != CNT_W'(CELLS));
  assign sweep_done = (rd_idx == CNT_W'(CELLS)) && !s1_vld && !s2_vld;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (op_in)
            OP_LOAD, OP_MARK:        state_next = cell_hit ? ST_CELL : ST_FINISH;
            OP_CLEAR_LEVELS, OP_FADE: state_next = ST_SWEEP;
            default:                 state_next = ST_FINISH;
          endcase
        end
      end
      ST_CELL:   state_next = ST_FINISH;
      ST_SWEEP:  if (sweep_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and RAM access.
  always_comb begin
    in_stall  = 1'b1;
    ram_raddr = idx_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        ram_raddr = in_idx;
      end
      ST_CELL: begin
        if (op_q == OP_MARK) begin
          ram_we    = rd_pass;
          ram_wdata = {1'b1, mark_lvl};
        end else if (!wall_q) begin
          ram_we    = !rd_pass;
          ram_wdata = {1'b1, rd_lvl};
        end else begin
          // A wall load of a passable cell drops its level too.
          ram_we    = rd_pass;
          ram_wdata = '0;
        end
      end
      ST_SWEEP: begin
        ram_raddr = rd_idx[IDX_W-1:0];
        ram_we    = s2_vld && s2_pass;
        ram_waddr = s2_idx;
        ram_wdata = {1'b1, sweep_lvl};
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      grid_rows        <= 5'd11;
      grid_cols        <= 5'd11;
      cover_threshold  <= LVL_W'(1311);
      fade_factor      <= LVL_W'(65503);
      covered_counter  <= '0;
      passable_counter <= '0;
      cell_valid       <= '0;
      rvalid_q         <= 1'b0;
      rd_idx           <= '0;
      s1_vld           <= 1'b0;
      s2_vld           <= 1'b0;
      out_valid        <= 1'b0;
      op_q             <= OP_CLEAR_ALL;
    end else begin
      state    <= state_next;
      rvalid_q <= cell_valid[ram_raddr];
      s1_vld   <= issue;
      s2_vld   <= s1_vld;

      if (cfg_wr) begin
        case (cfg_idx)
          REG_GRID_ROWS:   grid_rows       <= pwdata[4:0];
          REG_GRID_COLS:   grid_cols       <= pwdata[4:0];
          REG_THRESHOLD:   cover_threshold <= pwdata[LVL_W-1:0];
          REG_FADE_FACTOR: fade_factor     <= pwdata[LVL_W-1:0];
          default: ;
        endcase
      end

      if (in_accept) begin
        op_q <= op_in;
        case (op_in)
          OP_CLEAR_ALL: begin
            cell_valid       <= '0;
            covered_counter  <= '0;
            passable_counter <= '0;
          end
          OP_CLEAR_LEVELS, OP_FADE: begin
            rd_idx          <= '0;
            covered_counter <= '0;
          end
          default: ;
        endcase
      end

      if (ram_we) begin
        cell_valid[ram_waddr] <= 1'b1;
      end

      if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end

      if (state == ST_CELL) begin
        if (op_q == OP_MARK) begin
          if (rd_pass && !(rd_lvl > cover_threshold) && (mark_lvl > cover_threshold)) begin
            covered_counter <= covered_counter + COV_W'(1);
          end
        end else if (!wall_q) begin
          if (!rd_pass) begin
            passable_counter <= passable_counter + CNT_W'(1);
          end
        end else if (rd_pass) begin
          if ((rd_lvl > cover_threshold) && (covered_counter != '0)) begin
            covered_counter <= covered_counter - COV_W'(1);
          end
          if (passable_counter != '0) begin
            passable_counter <= passable_counter - CNT_W'(1);
          end
        end
      end

      // Recount covered cells as the sweep writes them back.
      if (ram_we && (state == ST_SWEEP) && (sweep_lvl > cover_threshold)) begin
        covered_counter <= covered_counter + COV_W'(1);
      end

      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      idx_q    <= in_idx;
      wall_q   <= cell_is_wall;
      amount_q <= mark_amount;
    end
    s1_idx  <= rd_idx[IDX_W-1:0];
    s2_idx  <= s1_idx;
    s2_pass <= rd_pass;
    prod_q  <= PROD_W'(rd_lvl) * PROD_W'(fade_factor);
    if ((state == ST_FINISH) && out_free) begin
      covered_count  <= (covered_counter > COV_W'(COUNT_SAT)) ? COUNT_SAT :
                        covered_counter[8:0];
      passable_cells <= (passable_counter == '0) ? 9'd1 : 9'(passable_counter);
    end
  end

  `ASSERT_NEVER(a_pass_bound, clk, rst, passable_counter > CNT_W'(CELLS))
  `ASSERT_NEVER(a_sweep_bound, clk, rst, rd_idx > CNT_W'(CELLS))
  `ASSERT_PROP(a_result_posted, clk, rst, post_result |=> (out_valid && state == ST_IDLE))
  `ASSERT_PROP(a_out_hold, clk, rst, (out_valid && out_stall) |=> $stable(covered_count))

endmodule
